// ----- rtl/psoc_pkg.sv -----
// ----------------------------------------------------------------------------
// psoc_pkg: shared types and constants of the periodic sphere overlap check
// Default sizes, sequencer states, image index and distance unit status.
// ----------------------------------------------------------------------------
package psoc_pkg;

  localparam int PSOC_STORE_DEPTH = 4096;
  localparam int PSOC_COORD_BITS  = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SELF,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // offset selector per axis: 0 none, 1 first extra offset, 2 +L
  typedef struct packed {
    logic [1:0] kx;
    logic [1:0] ky;
    logic [1:0] kz;
  } img_idx_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } touch_stat_t;

endpackage

// ----- rtl/psoc_touch.sv -----
// ----------------------------------------------------------------------------
// psoc_touch: pipelined sphere pair touch test
// Three stages: axis distances, squares, sum and compare d^2 <= (ra+rb)^2.
// ----------------------------------------------------------------------------
module psoc_touch #(
  parameter int COORD_BITS = psoc_pkg::PSOC_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS+1:0] a_x,
  input  logic signed [COORD_BITS+1:0] a_y,
  input  logic signed [COORD_BITS+1:0] a_z,
  input  logic        [COORD_BITS-2:0] a_r,
  input  logic signed [COORD_BITS+1:0] b_x,
  input  logic signed [COORD_BITS+1:0] b_y,
  input  logic signed [COORD_BITS+1:0] b_z,
  input  logic        [COORD_BITS-2:0] b_r,
  output psoc_pkg::touch_stat_t        stat
);
  import psoc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS;

  function automatic logic [CW-1:0] adiff(input logic signed [CW-1:0] p,
                                          input logic signed [CW-1:0] q);
    logic signed [CW:0] d;
    logic [CW:0] n;
    d = {p[CW-1], p} - {q[CW-1], q};
    n = -d;
    return d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  logic          v1_r, v2_r, v3_r;
  logic [CW-1:0] dx_r, dy_r, dz_r;
  logic [CB-1:0] rs_r;
  logic          near2_r, near3_r;
  logic [SW-1:0] sqx_r, sqy_r, sqz_r, lim2_r, lim3_r;
  logic [SW+1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dx_r <= adiff(a_x, b_x);
    dy_r <= adiff(a_y, b_y);
    dz_r <= adiff(a_z, b_z);
    rs_r <= {1'b0, a_r} + {1'b0, b_r};
    // an axis beyond rsum rules the pair out, so squares need only CB bits
    near2_r <= (dx_r <= CW'(rs_r)) && (dy_r <= CW'(rs_r)) && (dz_r <= CW'(rs_r));
    sqx_r   <= SW'(dx_r[CB-1:0]) * SW'(dx_r[CB-1:0]);
    sqy_r   <= SW'(dy_r[CB-1:0]) * SW'(dy_r[CB-1:0]);
    sqz_r   <= SW'(dz_r[CB-1:0]) * SW'(dz_r[CB-1:0]);
    lim2_r  <= SW'(rs_r) * SW'(rs_r);
    near3_r <= near2_r;
    sum_r   <= (SW+2)'(sqx_r) + (SW+2)'(sqy_r) + (SW+2)'(sqz_r);
    lim3_r  <= lim2_r;
  end

  assign stat.hit  = v3_r && near3_r && (sum_r <= (SW+2)'(lim3_r));
  assign stat.busy = v1_r || v2_r || v3_r;

endmodule

// ----- rtl/periodic_sphere_overlap_check_top.sv -----
// ----------------------------------------------------------------------------
// periodic_sphere_overlap_check_top: sphere store with periodic overlap test
// Checks a candidate's periodic images against stored spheres and each other.
// ----------------------------------------------------------------------------
// One transaction at a time. A clear's result enters the output register from
// the finish state once it is free. A place request with F spheres held and N
// images (1 to 27) tests each image against the F stored spheres, each test
// one read of the sphere memory feeding one pass of the three-stage distance
// pipeline, then each pair of images from registered coordinates; the pipeline
// drains and the N images are written back one a cycle. A hit stops the test
// early and skips the write-back, and a full store skips it too. A finished
// result waits in the output register while the next transaction is taken.
module periodic_sphere_overlap_check_top #(
  parameter int STORE_DEPTH = psoc_pkg::PSOC_STORE_DEPTH,
  parameter int COORD_BITS  = psoc_pkg::PSOC_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [COORD_BITS-1:0]              cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [COORD_BITS-1:0]              in_center_x,
  input  logic [COORD_BITS-1:0]              in_center_y,
  input  logic [COORD_BITS-1:0]              in_center_z,
  input  logic [COORD_BITS-2:0]              in_sphere_radius,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_collided,
  output logic                               out_placed,
  output logic [4:0]                         out_image_count,
  output logic                               out_store_full,
  output logic [$clog2(STORE_DEPTH+1)-1:0]   out_stored_total
);
  import psoc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int RB = COORD_BITS - 1;
  localparam int CW = COORD_BITS + 2;
  localparam int MW = 3 * CW + RB;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [CB-1:0] box_r;
  logic          mode_r;
  logic [CB-1:0] cx_r, cy_r, cz_r;
  logic [RB-1:0] r_r;
  logic [1:0]    nx_r, ny_r, nz_r;
  logic          mx_r, my_r, mz_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] si_r, si_nxt;
  img_idx_t      ia_r, ia_nxt, ib_r, ib_nxt;
  logic          hit_r, placed_r, full_r;
  logic          issue, iss_self, mem_we, out_load, full_set, placed_set;
  logic          iss_v_r, iss_self_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic [MW-1:0] mem [STORE_DEPTH];
  logic [MW-1:0] mem_q_r;
  logic          out_valid_r;
  logic          out_collided_r, out_placed_r, out_full_r;
  logic [4:0]    out_count_r;
  logic [FW-1:0] out_total_r;

  logic          accept;
  logic [4:0]    img_cnt;
  logic          single, over, pipe_empty;
  logic [AW-1:0] si_end;
  touch_stat_t   tstat;
  logic signed [CW-1:0] ta_x, ta_y, ta_z;
  logic [RB-1:0] ta_r;

  function automatic logic [2:0] axis_setup(input logic [CB-1:0] c,
                                            input logic [RB-1:0] r,
                                            input logic [CB-1:0] len);
    logic hasm, hasp;
    logic [1:0] n;
    hasm = (len != '0) && (({1'b0, c} + (CB+1)'(r)) >= {1'b0, len});
    hasp = (len != '0) && (c <= CB'(r));
    n = {1'b0, hasm} + {1'b0, hasp} + 2'd1;
    return {n, hasm};
  endfunction

  function automatic logic signed [CW-1:0] img_coord(input logic [CB-1:0] c,
                                                     input logic [1:0] k,
                                                     input logic minus,
                                                     input logic [CB-1:0] len);
    logic signed [CW-1:0] lc, ll;
    lc = signed'({2'b00, c});
    ll = signed'({2'b00, len});
    if (k == 2'd0) return lc;
    else if (k == 2'd1 && minus) return lc - ll;
    else return lc + ll;
  endfunction

  function automatic logic img_last(input img_idx_t i, input logic [1:0] nx,
                                    input logic [1:0] ny, input logic [1:0] nz);
    return (i.kx == nx - 2'd1) && (i.ky == ny - 2'd1) && (i.kz == nz - 2'd1);
  endfunction

  // z runs fastest, then y, then x
  function automatic img_idx_t img_inc(input img_idx_t i, input logic [1:0] nx,
                                       input logic [1:0] ny, input logic [1:0] nz);
    img_idx_t o;
    o = i;
    if (i.kz != nz - 2'd1) begin
      o.kz = i.kz + 2'd1;
    end else begin
      o.kz = 2'd0;
      if (i.ky != ny - 2'd1) begin
        o.ky = i.ky + 2'd1;
      end else begin
        o.ky = 2'd0;
        o.kx = (i.kx != nx - 2'd1) ? i.kx + 2'd1 : 2'd0;
      end
    end
    return o;
  endfunction

  assign accept     = in_valid && in_ready;
  assign img_cnt    = 5'(nx_r) * 5'(ny_r) * 5'(nz_r);
  assign single     = (img_cnt == 5'd1);
  assign over       = ((FW+1)'(fill_r) + (FW+1)'(img_cnt)) > (FW+1)'(STORE_DEPTH);
  assign si_end     = AW'(fill_r - FW'(1));
  assign pipe_empty = !iss_v_r && !tstat.busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = in_mode ? ST_STORE : ST_FINISH;
      end
      ST_STORE: begin
        if (hit_r) state_nxt = ST_DRAIN;
        else if (fill_r == '0) state_nxt = ST_SELF;
        else if (img_last(ib_r, nx_r, ny_r, nz_r) && si_r == si_end) state_nxt = ST_SELF;
      end
      ST_SELF: begin
        if (hit_r || single) state_nxt = ST_DRAIN;
        else if (img_last(ib_r, nx_r, ny_r, nz_r) &&
                 img_last(img_inc(ia_r, nx_r, ny_r, nz_r), nx_r, ny_r, nz_r))
          state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = (hit_r || over) ? ST_FINISH : ST_WRITE;
      end
      ST_WRITE: begin
        if (img_last(ib_r, nx_r, ny_r, nz_r)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    iss_self   = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    full_set   = 1'b0;
    placed_set = 1'b0;
    ia_nxt     = ia_r;
    ib_nxt     = ib_r;
    si_nxt     = si_r;
    fill_nxt   = fill_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ia_nxt   = '0;
        ib_nxt   = '0;
        si_nxt   = '0;
        if (in_valid && !in_mode) fill_nxt = '0;
      end
      ST_STORE: begin
        if (!hit_r) begin
          if (fill_r == '0) begin
            ib_nxt = img_inc('0, nx_r, ny_r, nz_r);
          end else begin
            issue = 1'b1;
            if (img_last(ib_r, nx_r, ny_r, nz_r)) begin
              if (si_r == si_end) begin
                si_nxt = '0;
                ib_nxt = img_inc('0, nx_r, ny_r, nz_r);
              end else begin
                si_nxt = si_r + AW'(1);
                ib_nxt = '0;
              end
            end else begin
              ib_nxt = img_inc(ib_r, nx_r, ny_r, nz_r);
            end
          end
        end
      end
      ST_SELF: begin
        if (!hit_r && !single) begin
          issue    = 1'b1;
          iss_self = 1'b1;
          if (img_last(ib_r, nx_r, ny_r, nz_r)) begin
            ia_nxt = img_inc(ia_r, nx_r, ny_r, nz_r);
            ib_nxt = img_inc(img_inc(ia_r, nx_r, ny_r, nz_r), nx_r, ny_r, nz_r);
          end else begin
            ib_nxt = img_inc(ib_r, nx_r, ny_r, nz_r);
          end
        end
      end
      ST_DRAIN: begin
        ib_nxt = '0;
        if (pipe_empty && !hit_r && over) full_set = 1'b1;
      end
      ST_WRITE: begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + FW'(1);
        ib_nxt   = img_inc(ib_r, nx_r, ny_r, nz_r);
        if (img_last(ib_r, nx_r, ny_r, nz_r)) placed_set = 1'b1;
      end
      ST_FINISH: begin
        out_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_r       <= '1;
      fill_r      <= '0;
      si_r        <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      hit_r       <= 1'b0;
      placed_r    <= 1'b0;
      full_r      <= 1'b0;
      iss_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) box_r <= cfg_wr_data;
      fill_r  <= fill_nxt;
      si_r    <= si_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      iss_v_r <= issue;
      if (accept) begin
        hit_r    <= 1'b0;
        placed_r <= 1'b0;
        full_r   <= 1'b0;
      end else begin
        if (tstat.hit) hit_r <= 1'b1;
        if (placed_set) placed_r <= 1'b1;
        if (full_set) full_r <= 1'b1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (accept) begin
      mode_r <= in_mode;
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      cz_r   <= in_center_z;
      r_r    <= in_sphere_radius;
      {nx_r, mx_r} <= axis_setup(in_center_x, in_sphere_radius, box_r);
      {ny_r, my_r} <= axis_setup(in_center_y, in_sphere_radius, box_r);
      {nz_r, mz_r} <= axis_setup(in_center_z, in_sphere_radius, box_r);
    end
    iss_self_r <= iss_self;
    ax_r <= img_coord(cx_r, ia_r.kx, mx_r, box_r);
    ay_r <= img_coord(cy_r, ia_r.ky, my_r, box_r);
    az_r <= img_coord(cz_r, ia_r.kz, mz_r, box_r);
    bx_r <= img_coord(cx_r, ib_r.kx, mx_r, box_r);
    by_r <= img_coord(cy_r, ib_r.ky, my_r, box_r);
    bz_r <= img_coord(cz_r, ib_r.kz, mz_r, box_r);
    if (out_load) begin
      out_collided_r <= hit_r;
      out_placed_r   <= placed_r || placed_set;
      out_full_r     <= full_r;
      out_count_r    <= mode_r ? img_cnt : 5'd0;
      out_total_r    <= fill_r;
    end
  end

  // sphere store; reads and writes never overlap in one transaction,
  // so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we)
      mem[fill_r[AW-1:0]] <= {img_coord(cx_r, ib_r.kx, mx_r, box_r),
                              img_coord(cy_r, ib_r.ky, my_r, box_r),
                              img_coord(cz_r, ib_r.kz, mz_r, box_r), r_r};
    mem_q_r <= mem[si_r];
  end

  assign ta_x = iss_self_r ? ax_r : signed'(mem_q_r[MW-1 -: CW]);
  assign ta_y = iss_self_r ? ay_r : signed'(mem_q_r[MW-1-CW -: CW]);
  assign ta_z = iss_self_r ? az_r : signed'(mem_q_r[MW-1-2*CW -: CW]);
  assign ta_r = iss_self_r ? r_r  : mem_q_r[RB-1:0];

  psoc_touch #(
    .COORD_BITS (COORD_BITS)
  ) u_touch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (iss_v_r),
    .a_x      (ta_x),
    .a_y      (ta_y),
    .a_z      (ta_z),
    .a_r      (ta_r),
    .b_x      (bx_r),
    .b_y      (by_r),
    .b_z      (bz_r),
    .b_r      (r_r),
    .stat     (tstat)
  );

  assign out_valid        = out_valid_r;
  assign out_collided     = out_collided_r;
  assign out_placed       = out_placed_r;
  assign out_image_count  = out_count_r;
  assign out_store_full   = out_full_r;
  assign out_stored_total = out_total_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(STORE_DEPTH))
    else $error("store fill beyond depth");

  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> !hit_r && !full_r && pipe_empty)
    else $error("store write after collision or with tests in flight");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_mode |=> fill_r == '0)
    else $error("clear did not empty the store");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_collided_r) + 32'(out_placed_r) + 32'(out_full_r)) <= 1)
    else $error("result flags not exclusive");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for periodic_sphere_overlap_check_top
// A directed table followed by random place and clear requests, checked
// against a behavioral store model, with random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = psoc_pkg::PSOC_STORE_DEPTH;
  localparam int CB    = psoc_pkg::PSOC_COORD_BITS;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 2000000;

  localparam logic MODE_CLEAR = 1'b0;
  localparam logic MODE_PLACE = 1'b1;

  typedef struct packed {
    logic          mode;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [CB-1:0] cz;
    logic [CB-2:0] rad;
  } sphere_req_t;

  typedef struct packed {
    logic          collided;
    logic          placed;
    logic [4:0]    image_count;
    logic          store_full;
    logic [TW-1:0] stored_total;
  } overlap_res_t;

  // directed row: request, plus a typed-in result where it is obvious
  typedef struct packed {
    sphere_req_t  req;
    logic         has_known;
    overlap_res_t known;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CB-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [CB-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [CB-2:0] in_sphere_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_collided, out_placed, out_store_full;
  logic [4:0] out_image_count;
  logic [TW-1:0] out_stored_total;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  periodic_sphere_overlap_check_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_center_z(in_center_z), .in_sphere_radius(in_sphere_radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_collided(out_collided), .out_placed(out_placed),
    .out_image_count(out_image_count), .out_store_full(out_store_full),
    .out_stored_total(out_stored_total)
  );

  // ---------------- store model ----------------
  longint      mdl_x[DEPTH], mdl_y[DEPTH], mdl_z[DEPTH];
  longint      mdl_r[DEPTH];
  int          mdl_fill;
  longint      mdl_box;
  overlap_res_t expected_results[$];

  function automatic bit pair_touches(longint ax, longint ay, longint az, longint ar,
                                      longint bx, longint by, longint bz, longint br);
    longint rs, dx, dy, dz;
    rs = ar + br;
    dx = ax - bx; dy = ay - by; dz = az - bz;
    return (dx * dx + dy * dy + dz * dz) <= rs * rs;
  endfunction

  function automatic overlap_res_t place_or_clear(sphere_req_t q);
    overlap_res_t res;
    longint off[3][3];
    int nof[3];
    longint c[3];
    longint ix[27], iy[27], iz[27];
    int n;
    bit hit;
    res = '0;
    if (q.mode == MODE_CLEAR) begin
      mdl_fill = 0;
      return res;
    end
    c[0] = q.cx; c[1] = q.cy; c[2] = q.cz;
    for (int a = 0; a < 3; a++) begin
      nof[a] = 1; off[a][0] = 0;
      if (mdl_box != 0) begin
        if (c[a] + q.rad >= mdl_box) begin off[a][nof[a]] = -mdl_box; nof[a]++; end
        if (c[a] <= q.rad) begin off[a][nof[a]] = mdl_box; nof[a]++; end
      end
    end
    n = 0;
    for (int a = 0; a < nof[0]; a++)
      for (int b = 0; b < nof[1]; b++)
        for (int e = 0; e < nof[2]; e++) begin
          ix[n] = c[0] + off[0][a]; iy[n] = c[1] + off[1][b]; iz[n] = c[2] + off[2][e];
          n++;
        end
    hit = 0;
    for (int i = 0; i < mdl_fill && !hit; i++)
      for (int j = 0; j < n && !hit; j++)
        if (pair_touches(mdl_x[i], mdl_y[i], mdl_z[i], mdl_r[i],
                         ix[j], iy[j], iz[j], q.rad)) hit = 1;
    for (int i = 0; i < n && !hit; i++)
      for (int j = i + 1; j < n && !hit; j++)
        if (pair_touches(ix[i], iy[i], iz[i], q.rad, ix[j], iy[j], iz[j], q.rad)) hit = 1;
    if (!hit) begin
      if (mdl_fill + n > DEPTH) res.store_full = 1'b1;
      else begin
        for (int j = 0; j < n; j++) begin
          mdl_x[mdl_fill] = ix[j]; mdl_y[mdl_fill] = iy[j];
          mdl_z[mdl_fill] = iz[j]; mdl_r[mdl_fill] = q.rad;
          mdl_fill++;
        end
        res.placed = 1'b1;
      end
    end
    res.collided = hit;
    res.image_count = 5'(n);
    res.stored_total = TW'(mdl_fill);
    return res;
  endfunction

  // ---------------- checking ----------------
  int mismatches = 0;
  int accepted_in = 0;
  int idle_cycles = 0;
  bit rx_idle_en = 1'b1;
  bit rx_long_hold = 1'b0;
  bit timed_out = 1'b0;
  bit stim_done = 1'b0;
  overlap_res_t got, want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_collided, out_placed, out_image_count, out_store_full,
              out_stored_total};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_long_hold = 1'b0;
      end
      if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 17);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  // valid stays up from one transaction to the next unless a gap is taken
  task automatic send_request(sphere_req_t q, bit has_known, overlap_res_t known,
                              bit gaps);
    overlap_res_t pred;
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= q.mode; in_center_x <= q.cx; in_center_y <= q.cy;
    in_center_z <= q.cz; in_sphere_radius <= q.rad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = place_or_clear(q);
    if (has_known && pred !== known) $display("table row disagrees with model: %p", q);
    expected_results.insert(expected_results.size(), has_known ? known : pred);
    accepted_in++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_box(logic [CB-1:0] len);
    cfg_wr_en <= 1'b1; cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mdl_box = len;
  endtask

  function automatic sphere_req_t rand_place(int box, int rmax);
    sphere_req_t q;
    q.mode = MODE_PLACE;
    q.cx = CB'($urandom_range(0, box - 1));
    q.cy = CB'($urandom_range(0, box - 1));
    q.cz = CB'($urandom_range(0, box - 1));
    q.rad = (CB-1)'($urandom_range(0, rmax));
    return q;
  endfunction

  dir_row_t dir_table[8];
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [CB-2:0] RMAX = {(CB-1){1'b1}};

  initial begin
    sphere_req_t q;
    int box;
    mdl_box = 24'hFFFFFF;
    mdl_fill = 0;
    // clear after reset
    dir_table[0] = '{'{MODE_CLEAR, '0, '0, '0, '0}, 1'b1, '0};
    // centered tiny sphere: one image
    dir_table[1] = '{'{MODE_PLACE, 24'h800000, 24'h800000, 24'h800000, 23'd1},
                     1'b1, '{1'b0, 1'b1, 5'd1, 1'b0, TW'(1)}};
    // same again: collides with itself stored
    dir_table[2] = '{'{MODE_PLACE, 24'h800000, 24'h800000, 24'h800000, 23'd1},
                     1'b1, '{1'b1, 1'b0, 5'd1, 1'b0, TW'(1)}};
    // origin with radius 0: wraps on every axis, 8 images
    dir_table[3] = '{'{MODE_PLACE, '0, '0, '0, '0}, 1'b0, '0};
    // max corner, max radius: an image lands on the origin sphere
    dir_table[4] = '{'{MODE_PLACE, CMAX, CMAX, CMAX, RMAX}, 1'b0, '0};
    dir_table[5] = '{'{MODE_PLACE, CMAX, '0, 24'h123456, 23'd5}, 1'b0, '0};
    dir_table[6] = '{'{MODE_CLEAR, CMAX, CMAX, CMAX, RMAX}, 1'b1, '0};
    dir_table[7] = '{'{MODE_PLACE, 24'h400000, 24'hC00000, 24'h000010, 23'h10},
                     1'b0, '0};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) send_request(dir_table[i].req, dir_table[i].has_known,
                                        dir_table[i].known, 1'b1);
    wait_drained();

    // small box: many wraps and the 27-image case
    write_box(24'd1000);
    send_request('{MODE_PLACE, 24'd500, 24'd500, 24'd500, 23'd500}, 1'b0, '0, 1'b0);
    send_request('{MODE_CLEAR, '0, '0, '0, '0}, 1'b0, '0, 1'b0);
    send_request('{MODE_PLACE, 24'd2000, 24'd5, 24'd999, 23'd1}, 1'b0, '0, 1'b0);
    wait_drained();

    // zero box length: single image
    write_box('0);
    send_request('{MODE_PLACE, 24'd7, '0, CMAX, 23'd9}, 1'b0, '0, 1'b0);
    send_request('{MODE_CLEAR, '0, '0, '0, '0}, 1'b1, '0, 1'b0);
    wait_drained();

    // random phases over several box sizes; few spheres fit so tests stay short
    for (int ph = 0; ph < 4; ph++) begin
      box = (ph == 0) ? 1 : (ph == 1) ? 4000 : (ph == 2) ? 200000 : 16777215;
      write_box(CB'(box));
      if (ph == 2) rx_long_hold = 1'b1;
      for (int k = 0; k < 25; k++) begin
        if (ph == 3 && k == 12) rx_idle_en = 1'b0;
        if ($urandom_range(0, 11) == 0) begin
          q = '0; q.mode = MODE_CLEAR;
          q.cx = CB'($urandom); q.rad = (CB-1)'($urandom);
        end else if (ph == 3 && $urandom_range(0, 4) == 0) begin
          q.mode = MODE_PLACE;
          q.cx = CB'($urandom); q.cy = CB'($urandom); q.cz = CB'($urandom);
          q.rad = (CB-1)'($urandom);
        end else begin
          q = rand_place(box, box / 8 + 1);
        end
        send_request(q, 1'b0, '0, !(ph == 3 && k >= 12));
      end
      wait_drained();
    end

    // end on a tiny box with a clear
    write_box(24'd2);
    send_request('{MODE_CLEAR, '0, '0, '0, '0}, 1'b0, '0, 1'b0);
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    @(posedge rst_n);
    wait (accepted_in > 0);
    fork
      begin
        wait (stim_done && expected_results.size() == 0);
        repeat (50) @(negedge clk);
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("** periodic_sphere_overlap_check_top: FAILED **");
    end else if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** periodic_sphere_overlap_check_top: PASSED **");
    end else begin
      $display("** periodic_sphere_overlap_check_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- periodic_sphere_overlap_check_top.f -----
rtl/psoc_pkg.sv
rtl/psoc_touch.sv
rtl/periodic_sphere_overlap_check_top.sv
tb/sv/testbench.sv
